@@ hw/rtl/stcr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stcr_pkg
// Shared constants, codes and the glyph ROM for the scrolling text renderer.
// ----------------------------------------------------------------------------
package stcr_pkg;

  localparam int MAX_CHARS   = 32;
  localparam int BOARD_COLS  = 8;
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_MAX_W = 5;
  localparam int GAP_COLS    = 1;
  localparam int MS_PER_S    = 1000;

  localparam int IDX_W   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W   = $clog2(MAX_CHARS + 1);
  localparam int X_W     = (BOARD_COLS > 1) ? $clog2(BOARD_COLS) : 1;
  localparam int TW_W    = $clog2(MAX_CHARS * (GLYPH_MAX_W + GAP_COLS) + 1);
  localparam int POS_W   = TW_W + 1;            // signed text column
  localparam int NUM_W   = 32;                  // dividend width of the remainder unit
  localparam int DEN_W   = 10;                  // divisor width of the remainder unit
  localparam int SEC_W   = 23;                  // whole seconds of a 32-bit ms count
  localparam int FRAC_W  = 18;                  // leftover ms times scroll_speed
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Divide by 1000 as a shift by 3 and a multiply by ceil(2^36 / 125)
  localparam int          MS_RECIP_SH = 36;
  localparam logic [29:0] MS_RECIP    = 30'd549755814;

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SPEED = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_FRAC,
    ST_SUM,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_FETCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]                       w;
    logic [GLYPH_ROWS-1:0][GLYPH_MAX_W-1:0] rows;   // rows[y], bit 4 is leftmost
  } glyph_t;

  // Whole seconds of a millisecond count; exact for every 32-bit input.
  function automatic logic [SEC_W-1:0] ms_to_sec(input logic [31:0] v);
    logic [58:0] p;
    p = 59'(v[31:3]) * 59'(MS_RECIP);
    return p[58:MS_RECIP_SH];
  endfunction

  function automatic glyph_t gl(input logic [2:0] w, input logic [4:0] b0,
                                input logic [4:0] b1, input logic [4:0] b2,
                                input logic [4:0] b3, input logic [4:0] b4);
    glyph_t g;
    g.w       = w;
    g.rows[0] = b0;
    g.rows[1] = b1;
    g.rows[2] = b2;
    g.rows[3] = b3;
    g.rows[4] = b4;
    return g;
  endfunction

  // Glyph ROM; anything not listed draws as a question mark.
  function automatic glyph_t font_lookup(input logic [7:0] ch);
    glyph_t g;
    case (ch)
      "A": g = gl(3'd4, 5'h0C, 5'h12, 5'h1E, 5'h12, 5'h12);
      "B": g = gl(3'd4, 5'h1C, 5'h12, 5'h1C, 5'h12, 5'h1C);
      "C": g = gl(3'd4, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E);
      "D": g = gl(3'd4, 5'h1C, 5'h12, 5'h12, 5'h12, 5'h1C);
      "E": g = gl(3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h1C);
      "F": g = gl(3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h10);
      "G": g = gl(3'd4, 5'h0E, 5'h10, 5'h16, 5'h12, 5'h0E);
      "H": g = gl(3'd4, 5'h12, 5'h12, 5'h1E, 5'h12, 5'h12);
      "I": g = gl(3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h1C);
      "J": g = gl(3'd4, 5'h06, 5'h02, 5'h02, 5'h12, 5'h0C);
      "K": g = gl(3'd4, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12);
      "L": g = gl(3'd3, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1C);
      "M": g = gl(3'd5, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11);
      "N": g = gl(3'd4, 5'h12, 5'h1A, 5'h16, 5'h12, 5'h12);
      "O": g = gl(3'd4, 5'h0C, 5'h12, 5'h12, 5'h12, 5'h0C);
      "P": g = gl(3'd4, 5'h1C, 5'h12, 5'h1C, 5'h10, 5'h10);
      "Q": g = gl(3'd4, 5'h0C, 5'h12, 5'h12, 5'h14, 5'h0A);
      "R": g = gl(3'd4, 5'h1C, 5'h12, 5'h1C, 5'h14, 5'h12);
      "S": g = gl(3'd4, 5'h0E, 5'h10, 5'h0C, 5'h02, 5'h1C);
      "T": g = gl(3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h08);
      "U": g = gl(3'd4, 5'h12, 5'h12, 5'h12, 5'h12, 5'h0C);
      "V": g = gl(3'd3, 5'h14, 5'h14, 5'h14, 5'h14, 5'h08);
      "W": g = gl(3'd5, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11);
      "X": g = gl(3'd3, 5'h14, 5'h14, 5'h08, 5'h14, 5'h14);
      "Y": g = gl(3'd3, 5'h14, 5'h14, 5'h08, 5'h08, 5'h08);
      "Z": g = gl(3'd4, 5'h1E, 5'h02, 5'h0C, 5'h10, 5'h1E);
      " ": g = gl(3'd2, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
      "!": g = gl(3'd1, 5'h10, 5'h10, 5'h10, 5'h00, 5'h10);
      "0": g = gl(3'd3, 5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C);
      "1": g = gl(3'd3, 5'h08, 5'h18, 5'h08, 5'h08, 5'h1C);
      "2": g = gl(3'd3, 5'h18, 5'h04, 5'h08, 5'h10, 5'h1C);
      "3": g = gl(3'd3, 5'h18, 5'h04, 5'h08, 5'h04, 5'h18);
      "4": g = gl(3'd3, 5'h14, 5'h14, 5'h1C, 5'h04, 5'h04);
      "5": g = gl(3'd3, 5'h1C, 5'h10, 5'h18, 5'h04, 5'h18);
      "6": g = gl(3'd3, 5'h0C, 5'h10, 5'h1C, 5'h14, 5'h1C);
      "7": g = gl(3'd3, 5'h1C, 5'h04, 5'h08, 5'h08, 5'h08);
      "8": g = gl(3'd3, 5'h1C, 5'h14, 5'h1C, 5'h14, 5'h1C);
      "9": g = gl(3'd3, 5'h1C, 5'h14, 5'h1C, 5'h04, 5'h18);
      "-": g = gl(3'd3, 5'h00, 5'h00, 5'h1C, 5'h00, 5'h00);
      ".": g = gl(3'd1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h10);
      default: g = gl(3'd3, 5'h18, 5'h04, 5'h08, 5'h00, 5'h08);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/stcr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stcr_div
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module stcr_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [stcr_pkg::NUM_W-1:0] dividend_i,
  input  wire logic [stcr_pkg::DEN_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [stcr_pkg::DEN_W-1:0]     remainder_o
);
  import stcr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

@@ hw/rtl/scrolling_text_column_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scrolling_text_column_renderer
// Stores a short text and renders one 5-row frame of a scrolling marquee.
// ----------------------------------------------------------------------------
// Drive an item on start while busy is low. Clear and append leave busy low
// and return nothing. A render raises busy and, after the scroll position is
// known, sends BOARD_COLS column beats, leftmost first, each on the result
// ports for exactly one cycle with result_valid_o high and last_o on the
// final one; the receiver cannot stall, so capture every flagged beat.
// While a render keeps busy high, ST_SEC, ST_FRAC and ST_SUM turn the
// elapsed time into a column step (divide by 1000 through a reciprocal
// multiply), the bit-serial remainder unit wraps it at the text period,
// ST_FETCH reads the first glyph, and ST_EMIT sends each column beat; each
// glyph walked past on the way to the left edge of the board costs one
// compare in ST_EMIT and one memory read in ST_FETCH. The last beat is on
// the ports in the first idle cycle.
// Configuration writes belong to idle time only.
// ----------------------------------------------------------------------------
module scrolling_text_column_renderer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command side
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action_i,
  input  wire logic [7:0]                    character_i,
  input  wire logic [31:0]                   scroll_ms_i,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [stcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [stcr_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // result beats
  output logic                               result_valid_o,
  output logic [2:0]                         column_o,
  output logic [4:0]                         lit_rows_o,
  output logic [23:0]                        color_o,
  output logic                               last_o
);
  import stcr_pkg::*;

  // Configuration registers
  logic [23:0] color_cfg_q;
  logic [7:0]  speed_cfg_q;

  // Text bookkeeping
  logic [LEN_W-1:0] len_q, len_d;
  logic [TW_W-1:0]  width_q, width_d;

  // Text memory: one write port for appends, one registered read port
  logic [7:0]       text_mem [MAX_CHARS];
  logic [7:0]       rdata_q;
  logic             mem_we;

  // Render sequencer
  state_e            state_q, state_d;
  logic [31:0]       ms_q, ms_d;         // elapsed time of the frame
  logic [SEC_W-1:0]  sec_q, sec_d;       // whole seconds
  logic [FRAC_W-1:0] frac_q, frac_d;     // leftover ms times speed
  logic [NUM_W-1:0]  num_q, num_d;       // scroll step plus BOARD_COLS
  logic [POS_W-1:0]  pos_q, pos_d;       // signed text column of the current board column
  logic [IDX_W-1:0]  gi_q, gi_d;         // glyph index being walked
  logic [TW_W-1:0]   gs_q, gs_d;         // first text column of that glyph
  logic [X_W-1:0]    x_q, x_d;

  // Output beat registers
  logic             ovalid_q, ovalid_d;
  logic [2:0]       ocol_q, ocol_d;
  logic [4:0]       orows_q, orows_d;
  logic [23:0]      ocolor_q, ocolor_d;
  logic             olast_q, olast_d;

  // Remainder unit hookup
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DEN_W-1:0] div_rem;

  logic             accept;
  glyph_t           app_glyph;
  glyph_t           cur_glyph;
  logic             in_text;
  logic [TW_W:0]    glyph_end;
  logic             advance;
  logic [2:0]       gx;
  logic [4:0]       col_mask;
  logic [19:0]      sec_ms;
  logic [9:0]       rem_ms;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign app_glyph = font_lookup(character_i);
  assign cur_glyph = font_lookup(rdata_q);

  // Milliseconds left over after the whole seconds; below 1000, so the low
  // ten bits of the difference are exact
  assign sec_ms = 20'(sec_q[9:0]) * 20'(MS_PER_S);
  assign rem_ms = ms_q[9:0] - sec_ms[9:0];

  // Where the current board column lands in the text
  assign in_text   = !pos_q[POS_W-1] && (pos_q[TW_W-1:0] < width_q);
  assign glyph_end = {1'b0, gs_q} + (TW_W+1)'(cur_glyph.w) + (TW_W+1)'(GAP_COLS);
  assign advance   = in_text && ({1'b0, pos_q[TW_W-1:0]} >= glyph_end);
  assign gx        = 3'(pos_q[TW_W-1:0] - gs_q);

  always_comb begin
    col_mask = '0;
    if (gx < cur_glyph.w) begin
      for (int y = 0; y < GLYPH_ROWS; y++) begin
        col_mask[y] = cur_glyph.rows[y][3'(GLYPH_MAX_W - 1) - gx];
      end
    end
  end

  // Config writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_cfg_q <= 24'hFF_FFFF;
      speed_cfg_q <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEXT_COLOR:   color_cfg_q <= cfg_wdata_i[23:0];
        REG_SCROLL_SPEED: speed_cfg_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Text memory
  assign mem_we = accept && (action_i == ACT_APPEND) && (len_q < LEN_W'(MAX_CHARS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      text_mem[len_q[IDX_W-1:0]] <= character_i;
    end
    rdata_q <= text_mem[gi_q];
  end

  stcr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      width_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      width_q  <= width_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q     <= ms_d;
    sec_q    <= sec_d;
    frac_q   <= frac_d;
    num_q    <= num_d;
    pos_q    <= pos_d;
    gi_q     <= gi_d;
    gs_q     <= gs_d;
    x_q      <= x_d;
    ocol_q   <= ocol_d;
    orows_q  <= orows_d;
    ocolor_q <= ocolor_d;
    olast_q  <= olast_d;
  end

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    width_d   = width_q;
    ms_d      = ms_q;
    sec_d     = sec_q;
    frac_d    = frac_q;
    num_d     = num_q;
    pos_d     = pos_q;
    gi_d      = gi_q;
    gs_d      = gs_q;
    x_d       = x_q;
    ovalid_d  = 1'b0;
    ocol_d    = ocol_q;
    orows_d   = orows_q;
    ocolor_d  = ocolor_q;
    olast_d   = olast_q;
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = DEN_W'(width_q) + DEN_W'(BOARD_COLS);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_CLEAR: begin
              len_d   = '0;
              width_d = '0;
            end
            ACT_APPEND: begin
              if (mem_we) begin
                len_d   = len_q + 1'b1;
                width_d = width_q + TW_W'(app_glyph.w) + TW_W'(GAP_COLS);
              end
            end
            ACT_RENDER: begin
              ms_d    = scroll_ms_i;
              state_d = ST_SEC;
            end
            default: ;
          endcase
        end
      end
      ST_SEC: begin
        sec_d   = ms_to_sec(ms_q);
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        frac_d  = FRAC_W'(rem_ms) * FRAC_W'(speed_cfg_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // seconds times speed plus the columns gained in the leftover time, plus BOARD_COLS
        num_d   = NUM_W'(sec_q) * NUM_W'(speed_cfg_q)
                + NUM_W'(ms_to_sec(32'(frac_q))) + NUM_W'(BOARD_COLS);
        state_d = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        div_start = 1'b1;
        state_d   = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_done) begin
          // left edge of the board in text columns
          pos_d   = POS_W'(div_rem) - POS_W'(BOARD_COLS);
          gi_d    = '0;
          gs_d    = '0;
          x_d     = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // read of gi_q lands in rdata_q at the end of this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (advance) begin
          gs_d    = glyph_end[TW_W-1:0];
          gi_d    = gi_q + 1'b1;
          state_d = ST_FETCH;
        end else begin
          ovalid_d = 1'b1;
          ocol_d   = 3'(x_q);
          orows_d  = in_text ? col_mask : 5'd0;
          ocolor_d = color_cfg_q;
          olast_d  = (x_q == X_W'(BOARD_COLS - 1));
          pos_d    = pos_q + 1'b1;
          x_d      = x_q + 1'b1;
          if (x_q == X_W'(BOARD_COLS - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o = ovalid_q;
  assign column_o       = ocol_q;
  assign lit_rows_o     = orows_q;
  assign color_o        = ocolor_q;
  assign last_o         = olast_q;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scrolling text column renderer. A built-in
// marquee predictor follows every accepted command, queues the column beats
// that each render must produce, and a checker compares every flagged result
// beat, field by field, against the oldest queued column.
// ----------------------------------------------------------------------------
module tb_top;
  import stcr_pkg::*;

  localparam logic [1:0]           ACT_IGNORED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3   = 2'd3;
  // Long enough to cover a whole render.
  localparam int                   SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [2:0]  column;
    logic [4:0]  lit_rows;
    logic [23:0] color;
    logic        last;
  } column_beat_t;

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           action_i;
  logic [7:0]           character_i;
  logic [31:0]          scroll_ms_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 result_valid_o;
  logic [2:0]           column_o;
  logic [4:0]           lit_rows_o;
  logic [23:0]          color_o;
  logic                 last_o;

  scrolling_text_column_renderer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .character_i    (character_i),
    .scroll_ms_i    (scroll_ms_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .column_o       (column_o),
    .lit_rows_o     (lit_rows_o),
    .color_o        (color_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Marquee predictor state: stored text, its width and the two registers
  // --------------------------------------------------------------------------
  logic [7:0]   text_mem [MAX_CHARS];
  int           text_len;
  int           text_cols;
  logic [23:0]  color_reg;
  logic [7:0]   speed_reg;

  column_beat_t expected_cols_q [$];
  int           mismatch_count;
  int           accepted_items;
  string        glyph_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ !?0123456789-.";

  // Font shape: {width, row0 .. row4}; within a row bit 4 is the leftmost
  // column. Anything outside the font draws as a question mark.
  function automatic logic [27:0] glyph_shape(input logic [7:0] code);
    logic [27:0] shape;
    case (code)
      "A": shape = {3'd4, 5'h0C, 5'h12, 5'h1E, 5'h12, 5'h12};
      "B": shape = {3'd4, 5'h1C, 5'h12, 5'h1C, 5'h12, 5'h1C};
      "C": shape = {3'd4, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
      "D": shape = {3'd4, 5'h1C, 5'h12, 5'h12, 5'h12, 5'h1C};
      "E": shape = {3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h1C};
      "F": shape = {3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h10};
      "G": shape = {3'd4, 5'h0E, 5'h10, 5'h16, 5'h12, 5'h0E};
      "H": shape = {3'd4, 5'h12, 5'h12, 5'h1E, 5'h12, 5'h12};
      "I": shape = {3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h1C};
      "J": shape = {3'd4, 5'h06, 5'h02, 5'h02, 5'h12, 5'h0C};
      "K": shape = {3'd4, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      "L": shape = {3'd3, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1C};
      "M": shape = {3'd5, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
      "N": shape = {3'd4, 5'h12, 5'h1A, 5'h16, 5'h12, 5'h12};
      "O": shape = {3'd4, 5'h0C, 5'h12, 5'h12, 5'h12, 5'h0C};
      "P": shape = {3'd4, 5'h1C, 5'h12, 5'h1C, 5'h10, 5'h10};
      "Q": shape = {3'd4, 5'h0C, 5'h12, 5'h12, 5'h14, 5'h0A};
      "R": shape = {3'd4, 5'h1C, 5'h12, 5'h1C, 5'h14, 5'h12};
      "S": shape = {3'd4, 5'h0E, 5'h10, 5'h0C, 5'h02, 5'h1C};
      "T": shape = {3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h08};
      "U": shape = {3'd4, 5'h12, 5'h12, 5'h12, 5'h12, 5'h0C};
      "V": shape = {3'd3, 5'h14, 5'h14, 5'h14, 5'h14, 5'h08};
      "W": shape = {3'd5, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
      "X": shape = {3'd3, 5'h14, 5'h14, 5'h08, 5'h14, 5'h14};
      "Y": shape = {3'd3, 5'h14, 5'h14, 5'h08, 5'h08, 5'h08};
      "Z": shape = {3'd4, 5'h1E, 5'h02, 5'h0C, 5'h10, 5'h1E};
      " ": shape = {3'd2, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      "!": shape = {3'd1, 5'h10, 5'h10, 5'h10, 5'h00, 5'h10};
      "0": shape = {3'd3, 5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C};
      "1": shape = {3'd3, 5'h08, 5'h18, 5'h08, 5'h08, 5'h1C};
      "2": shape = {3'd3, 5'h18, 5'h04, 5'h08, 5'h10, 5'h1C};
      "3": shape = {3'd3, 5'h18, 5'h04, 5'h08, 5'h04, 5'h18};
      "4": shape = {3'd3, 5'h14, 5'h14, 5'h1C, 5'h04, 5'h04};
      "5": shape = {3'd3, 5'h1C, 5'h10, 5'h18, 5'h04, 5'h18};
      "6": shape = {3'd3, 5'h0C, 5'h10, 5'h1C, 5'h14, 5'h1C};
      "7": shape = {3'd3, 5'h1C, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": shape = {3'd3, 5'h1C, 5'h14, 5'h1C, 5'h14, 5'h1C};
      "9": shape = {3'd3, 5'h1C, 5'h14, 5'h1C, 5'h04, 5'h18};
      "-": shape = {3'd3, 5'h00, 5'h00, 5'h1C, 5'h00, 5'h00};
      ".": shape = {3'd1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h10};
      default: shape = {3'd3, 5'h18, 5'h04, 5'h08, 5'h00, 5'h08};
    endcase
    return shape;
  endfunction

  // Lit rows of absolute text column t: walk the glyphs, each followed by
  // one blank spacing column.
  function automatic logic [4:0] text_column_rows(input int t);
    logic [27:0] shape;
    logic [4:0]  rows;
    int          origin;
    int          w;
    int          gx;
    int          i;
    int          y;
    origin = 0;
    rows   = '0;
    for (i = 0; i < text_len; i++) begin
      shape = glyph_shape(text_mem[i]);
      w     = int'(shape[27:25]);
      if (t < origin + w + GAP_COLS) begin
        gx = t - origin;
        if (gx < w) begin
          for (y = 0; y < GLYPH_ROWS; y++) rows[y] = shape[24 - 5*y - gx];
        end
        return rows;
      end
      origin += w + GAP_COLS;
    end
    return rows;
  endfunction

  // Turn elapsed time into the scroll position and queue one beat per column.
  task automatic predict_frame(input logic [31:0] ms);
    logic [63:0]  travel;
    logic [63:0]  period;
    logic [63:0]  offset;
    int           left;
    int           t;
    int           x;
    column_beat_t beat;
    travel = 64'(ms) * 64'(speed_reg);
    period = 64'(text_cols + BOARD_COLS);
    offset = (travel / MS_PER_S + BOARD_COLS) % period;
    left   = int'(offset) - BOARD_COLS;
    for (x = 0; x < BOARD_COLS; x++) begin
      t             = left + x;
      beat.column   = 3'(x);
      beat.lit_rows = (t >= 0 && t < text_cols) ? text_column_rows(t) : 5'd0;
      beat.color    = color_reg;
      beat.last     = (x == BOARD_COLS - 1);
      expected_cols_q.push_back(beat);
    end
  endtask

  task automatic apply_command(input logic [1:0] act, input logic [7:0] ch,
                               input logic [31:0] ms);
    logic [27:0] shape;
    case (act)
      ACT_CLEAR: begin
        text_len  = 0;
        text_cols = 0;
      end
      ACT_APPEND: begin
        // A full store drops further characters.
        if (text_len < MAX_CHARS) begin
          shape              = glyph_shape(ch);
          text_mem[text_len] = ch;
          text_len++;
          text_cols += int'(shape[27:25]) + GAP_COLS;
        end
      end
      ACT_RENDER: predict_frame(ms);
      default: ;
    endcase
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    if (idx == REG_TEXT_COLOR) color_reg = data[23:0];
    else if (idx == REG_SCROLL_SPEED) speed_reg = data[7:0];
  endtask

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so grab every flagged beat
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("tb: mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_beats
    column_beat_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (expected_cols_q.size() == 0) begin
        log_mismatch("unexpected beat, column", 32'(column_o), 32'hFFFF_FFFF);
      end else begin
        want = expected_cols_q.pop_front();
        if (column_o !== want.column)
          log_mismatch("column", 32'(column_o), 32'(want.column));
        if (lit_rows_o !== want.lit_rows)
          log_mismatch("lit_rows", 32'(lit_rows_o), 32'(want.lit_rows));
        if (color_o !== want.color)
          log_mismatch("color", 32'(color_o), 32'(want.color));
        if (last_o !== want.last)
          log_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving helpers: inputs move on the falling edge, handshakes are seen on
  // the rising edge
  // --------------------------------------------------------------------------

  // Hold start high until the block takes the command; leave it high so a
  // back-to-back command needs no extra edge.
  task automatic send_command(input logic [1:0] act, input logic [7:0] ch,
                              input logic [31:0] ms);
    @(negedge clk_i);
    start        = 1'b1;
    action_i     = act;
    character_i  = ch;
    scroll_ms_i  = ms;
    do @(posedge clk_i); while (busy);
    // Ignored actions and appends into a full store do not count as traffic.
    if (act != ACT_IGNORED && !(act == ACT_APPEND && text_len >= MAX_CHARS))
      accepted_items++;
    apply_command(act, ch, ms);
  endtask

  // Drop start for a random idle gap, drawn against idle_pct.
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_cols_q.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only while the block is idle: drain, then let a full
  // render's worth of cycles pass in case a command is still in flight.
  task automatic settle_block();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(3) != 0) return glyph_chars[$urandom_range(glyph_chars.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Half the frames land in the first minute of scrolling, half anywhere.
  function automatic logic [31:0] pick_ms();
    if ($urandom_range(1) != 0) return 32'($urandom_range(60000));
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Defaults after reset: white text at eight columns per second.
  task automatic test_reset_defaults();
    send_command(ACT_RENDER, 8'h00, 32'd0);           // empty text stays dark
    send_command(ACT_APPEND, "A", 32'd0);
    send_command(ACT_RENDER, 8'h00, 32'd0);           // glyph sits at the left edge
    send_command(ACT_RENDER, 8'h00, 32'd1000);        // one second of scroll
  endtask

  // Unknown codes, the reserved action and the extreme times.
  task automatic test_odd_characters();
    send_command(ACT_APPEND, 8'h00, 32'h0);
    send_command(ACT_APPEND, 8'hFF, 32'hFFFF_FFFF);
    send_command(ACT_APPEND, "?", 32'h0);
    send_command(ACT_IGNORED, 8'hFF, 32'hFFFF_FFFF);
    send_command(ACT_RENDER, 8'h00, 32'hFFFF_FFFF);
    send_command(ACT_RENDER, 8'hFF, 32'h0);
    send_command(ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    send_command(ACT_RENDER, 8'h00, $urandom);
  endtask

  // Register extremes, spare indexes and a stalled scroll.
  task automatic test_register_extremes();
    settle_block();
    write_register(REG_TEXT_COLOR, 24'h000000);
    write_register(REG_SCROLL_SPEED, 24'hFFFFFF);     // upper bits must drop
    write_register(REG_SPARE_2, 24'($urandom));
    write_register(REG_SPARE_3, 24'($urandom));
    send_command(ACT_APPEND, "M", 32'h0);
    send_command(ACT_APPEND, "W", 32'h0);
    send_command(ACT_APPEND, "!", 32'h0);
    send_command(ACT_APPEND, ".", 32'h0);
    send_command(ACT_RENDER, 8'h00, 32'hFFFF_FFFF);
    settle_block();
    write_register(REG_SCROLL_SPEED, 24'h000000);
    send_command(ACT_RENDER, 8'h00, $urandom);
    send_command(ACT_RENDER, 8'h00, $urandom);
    settle_block();
    write_register(REG_SCROLL_SPEED, 24'h000001);
    write_register(REG_TEXT_COLOR, 24'hFFFFFF);
    send_command(ACT_RENDER, 8'h00, 32'd999);
    send_command(ACT_RENDER, 8'h00, 32'd1000);
  endtask

  // Mostly clear / load / render sequences with random content; the rest is
  // loose commands on whatever text is stored. Now and then pause until the
  // block has delivered every pending column.
  task automatic run_traffic(input int quota, input int idle_pct);
    int base;
    int n_chars;
    base = accepted_items;
    while (accepted_items - base < quota) begin
      if ($urandom_range(9) < 8) begin
        sender_gap(idle_pct);
        send_command(ACT_CLEAR, 8'($urandom), $urandom);
        n_chars = ($urandom_range(5) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 12);
        repeat (n_chars) begin
          sender_gap(idle_pct);
          send_command(ACT_APPEND, pick_char(), $urandom);
        end
        repeat ($urandom_range(1, 4)) begin
          sender_gap(idle_pct);
          send_command(ACT_RENDER, 8'($urandom), pick_ms());
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          sender_gap(idle_pct);
          send_command(2'($urandom_range(3)), 8'($urandom), $urandom);
        end
      end
      if ($urandom_range(24) == 0) hold_until_drained();
    end
  endtask

  // Three idling phases, each under a different register setting.
  task automatic test_scroll_traffic();
    settle_block();
    write_register(REG_TEXT_COLOR, 24'($urandom));
    write_register(REG_SCROLL_SPEED, 24'($urandom_range(1, 255)));
    run_traffic(85, 0);
    settle_block();
    write_register(REG_TEXT_COLOR, 24'($urandom));
    write_register(REG_SCROLL_SPEED, (24'($urandom) & 24'hFFFF00) | 24'd1);
    run_traffic(85, 54);
    settle_block();
    write_register(REG_TEXT_COLOR, 24'($urandom));
    write_register(REG_SCROLL_SPEED, (24'($urandom) & 24'hFFFF00) | 24'd255);
    run_traffic(70, 9);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    action_i       = ACT_CLEAR;
    character_i    = '0;
    scroll_ms_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_TEXT_COLOR;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    accepted_items = 0;
    text_len       = 0;
    text_cols      = 0;
    color_reg      = 24'hFFFFFF;
    speed_reg      = 8'd8;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_odd_characters();
    test_register_extremes();
    test_scroll_traffic();

    // Let the last frame drain, then give the block time to show any stray beat.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ scrolling_text_column_renderer.f @@
hw/rtl/stcr_pkg.sv
hw/rtl/stcr_div.sv
hw/rtl/scrolling_text_column_renderer.sv
tb/tb_top.sv
